/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the checker file of this block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk, switched off while rst is high.
`define HMT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hmt_checker: property violated");

// Concurrent assertion on clk that also holds during reset.
`define HMT_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hmt_checker: reset property violated");

`endif

/* hdl/hmt_pkg.sv */
// ---------------------------------------------------------------------------
// hmt_pkg
// Types, codes and defaults shared by the heightmap traversability check.
// ---------------------------------------------------------------------------
package hmt_pkg;

  // Default sizes of the grid and of a stored height.
  localparam int MAX_X_DEF       = 256;
  localparam int MAX_Y_DEF       = 256;
  localparam int HEIGHT_BITS_DEF = 8;

  // Minimum count of close neighbors for a continuous surface.
  localparam int NEED_CLOSE = 5;

  // Port widths fixed by the field layout.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 28;
  localparam int S_DATA_W   = 32;
  localparam int M_DATA_W   = 8;
  localparam int SIZE_W     = 9;
  localparam int HDIFF_W    = 12;
  localparam int SLOPE_W    = 28;
  localparam int STEP_W     = 4;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_X = 2'd0,
    CFG_GRID_Y = 2'd1,
    CFG_HDIFF  = 2'd2,
    CFG_SLOPE  = 2'd3
  } cfg_idx_t;

  // Reason codes of a query result.
  typedef enum logic [2:0] {
    RSN_OK         = 3'd0,
    RSN_BLOCKED    = 3'd1,
    RSN_NO_SURFACE = 3'd2,
    RSN_DISCONT    = 3'd3,
    RSN_STEEP      = 3'd4,
    RSN_INFLATED   = 3'd5
  } reason_t;

  // Offset of a read along one axis: minus one, zero, plus one.
  typedef enum logic [1:0] {
    OFF_M = 2'd0,
    OFF_Z = 2'd1,
    OFF_P = 2'd2
  } off_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR = 3'd0,
    ST_IDLE  = 3'd1,
    ST_RUN   = 3'd2,
    ST_GRAD  = 3'd3,
    ST_SQX   = 3'd4,
    ST_SQY   = 3'd5,
    ST_DONE  = 3'd6
  } state_t;

  // Read steps of a query: the center first, then the eight neighbors.
  localparam logic [STEP_W-1:0] TAG_CENTER = 4'd0;
  localparam logic [STEP_W-1:0] TAG_XM     = 4'd2;
  localparam logic [STEP_W-1:0] TAG_YM     = 4'd4;
  localparam logic [STEP_W-1:0] TAG_YP     = 4'd5;
  localparam logic [STEP_W-1:0] TAG_XP     = 4'd7;
  localparam logic [STEP_W-1:0] LAST_READ  = 4'd8;
  localparam logic [STEP_W-1:0] LAST_STEP  = 4'd9;

  // X offset of read step k.
  function automatic off_t off_x(logic [STEP_W-1:0] k);
    off_t o;
    case (k)
      4'd1, 4'd2, 4'd3: o = OFF_M;
      4'd6, 4'd7, 4'd8: o = OFF_P;
      default:          o = OFF_Z;
    endcase
    return o;
  endfunction

  // Y offset of read step k.
  function automatic off_t off_y(logic [STEP_W-1:0] k);
    off_t o;
    case (k)
      4'd1, 4'd4, 4'd6: o = OFF_M;
      4'd3, 4'd5, 4'd8: o = OFF_P;
      default:          o = OFF_Z;
    endcase
    return o;
  endfunction

  // Control from the sequencer to the evaluation datapath.
  typedef struct packed {
    logic              start;
    logic              cap_center;
    logic              nb_use;
    logic [STEP_W-1:0] nb_sel;
    logic              nb_ok;
    logic              calc_g;
    logic              sq_x;
    logic              sq_y;
  } eval_ctl_t;

  // Classification handed back to the sequencer.
  typedef struct packed {
    reason_t    reason;
    logic [3:0] close_cnt;
  } eval_res_t;

endpackage

/* hdl/hmt_store.sv */
// ---------------------------------------------------------------------------
// hmt_store
// Column store: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module hmt_store #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16,
  parameter int DW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/hmt_eval.sv */
// ---------------------------------------------------------------------------
// hmt_eval
// Neighbor counting, slope estimate and reason selection for one query.
// ---------------------------------------------------------------------------
module hmt_eval #(
  parameter int HEIGHT_BITS = hmt_pkg::HEIGHT_BITS_DEF
) (
  input  logic                               clk,
  input  hmt_pkg::eval_ctl_t                 ctl,
  input  logic                               q_inside,
  input  logic [HEIGHT_BITS+2:0]             rdata,
  input  logic [hmt_pkg::HDIFF_W-1:0]        hdiff_limit,
  input  logic [hmt_pkg::SLOPE_W-1:0]        slope_limit,
  output hmt_pkg::eval_res_t                 res
);

  import hmt_pkg::*;

  localparam int H     = HEIGHT_BITS;
  localparam int GW    = H + 2;
  localparam int SQW   = 2 * GW;
  localparam int SUMW  = SQW + 1;
  localparam int LW    = SLOPE_W - 8;
  localparam int CMPW  = (SUMW > LW) ? SUMW : LW;
  localparam int DCW   = ((H + 4) > HDIFF_W) ? (H + 4) : HDIFF_W;

  // Center column.
  logic         c_blk;
  logic         c_val;
  logic         c_inf;
  logic [H-1:0] c_h;

  // Axis neighbors and the close count.
  logic         xp_ok, xm_ok, yp_ok, ym_ok;
  logic [H-1:0] xp_h, xm_h, yp_h, ym_h;
  logic [3:0]   close_cnt;

  // Slope datapath.
  logic signed [GW-1:0]  gx, gy;
  logic [SQW-1:0]        sqx, sqy;
  logic signed [GW-1:0]  sq_in;
  logic signed [SQW-1:0] sq_out;
  logic [SUMW-1:0]       sum;
  logic                  steep;

  logic [H-1:0] nb_h;
  logic [H-1:0] nb_d;
  logic         nb_present;
  logic         nb_close;

  // Doubled difference along one axis, one-sided where a side is missing.
  function automatic logic signed [GW-1:0] axis_diff(
    logic hp, logic [H-1:0] vp, logic hm, logic [H-1:0] vm, logic [H-1:0] hc);
    logic signed [GW-1:0] sp;
    logic signed [GW-1:0] sm;
    logic signed [GW-1:0] sc;
    logic signed [GW-1:0] d;
    sp = $signed({2'b00, vp});
    sm = $signed({2'b00, vm});
    sc = $signed({2'b00, hc});
    priority if (hp && hm) begin
      d = sp - sm;
    end else if (hp) begin
      d = (sp - sc) <<< 1;
    end else if (hm) begin
      d = (sc - sm) <<< 1;
    end else begin
      d = '0;
    end
    return d;
  endfunction

  // Height test of the neighbor beat on the read port.
  always_comb begin
    nb_h       = rdata[H-1:0];
    nb_present = ctl.nb_ok && rdata[H];
    nb_d       = (nb_h > c_h) ? (nb_h - c_h) : (c_h - nb_h);
    nb_close   = DCW'({nb_d, 4'b0000}) < DCW'(hdiff_limit);
  end

  // Center capture and neighbor accumulation.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      close_cnt <= '0;
      xp_ok     <= 1'b0;
      xm_ok     <= 1'b0;
      yp_ok     <= 1'b0;
      ym_ok     <= 1'b0;
    end else if (ctl.cap_center) begin
      c_h   <= rdata[H-1:0];
      c_val <= rdata[H];
      c_blk <= rdata[H+1];
      c_inf <= rdata[H+2];
    end else if (ctl.nb_use) begin
      if (nb_present && nb_close) begin
        close_cnt <= close_cnt + 4'd1;
      end
      unique case (ctl.nb_sel)
        TAG_XP: begin
          xp_ok <= nb_present;
          xp_h  <= nb_h;
        end
        TAG_XM: begin
          xm_ok <= nb_present;
          xm_h  <= nb_h;
        end
        TAG_YP: begin
          yp_ok <= nb_present;
          yp_h  <= nb_h;
        end
        TAG_YM: begin
          ym_ok <= nb_present;
          ym_h  <= nb_h;
        end
        default: begin
        end
      endcase
    end
  end

  // Axis differences.
  always_ff @(posedge clk) begin
    if (ctl.calc_g) begin
      gx <= axis_diff(xp_ok, xp_h, xm_ok, xm_h, c_h);
      gy <= axis_diff(yp_ok, yp_h, ym_ok, ym_h, c_h);
    end
  end

  // One squarer shared by both axes, x in ST_SQX and then y in ST_SQY.
  assign sq_in  = ctl.sq_x ? gx : gy;
  assign sq_out = sq_in * sq_in;

  always_ff @(posedge clk) begin
    if (ctl.sq_x) begin
      sqx <= $unsigned(sq_out);
    end
    if (ctl.sq_y) begin
      sqy <= $unsigned(sq_out);
    end
  end

  // 256 * sum > limit holds exactly when sum exceeds limit / 256.
  assign sum   = SUMW'(sqx) + SUMW'(sqy);
  assign steep = CMPW'(sum) > CMPW'(slope_limit[SLOPE_W-1:8]);

  // Reason in check order; the first failing check wins.
  always_comb begin
    res.close_cnt = close_cnt;
    priority if (!q_inside) begin
      res.reason    = RSN_NO_SURFACE;
      res.close_cnt = '0;
    end else if (c_blk) begin
      res.reason    = RSN_BLOCKED;
      res.close_cnt = '0;
    end else if (!c_val) begin
      res.reason    = RSN_NO_SURFACE;
      res.close_cnt = '0;
    end else if (close_cnt < 4'(NEED_CLOSE)) begin
      res.reason = RSN_DISCONT;
    end else if (steep) begin
      res.reason = RSN_STEEP;
    end else if (c_inf) begin
      res.reason = RSN_INFLATED;
    end else begin
      res.reason = RSN_OK;
    end
  end

endmodule

/* hdl/heightmap_traversability_check_top.sv */
// ---------------------------------------------------------------------------
// heightmap_traversability_check_top: takes write beats one per cycle while idle.
// A query reads nine columns through the single store read port, then squares
// both axis slopes on one multiplier; no beat is taken until the result is loaded.
// After reset a sweep clears MAX_X*MAX_Y entries, one per cycle, before s_tready.
// ---------------------------------------------------------------------------
module heightmap_traversability_check_top #(
  parameter int MAX_X       = hmt_pkg::MAX_X_DEF,
  parameter int MAX_Y       = hmt_pkg::MAX_Y_DEF,
  parameter int HEIGHT_BITS = hmt_pkg::HEIGHT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hmt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hmt_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Input stream.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // col_x[7:0], col_y[15:8], surface_height[23:16], surface_present[24],
  // vertical_block[25], inflated_mark[26], zero fill[31:27]
  input  logic [hmt_pkg::S_DATA_W-1:0]    s_tdata,
  // cmd[0]
  input  logic                            s_tuser,
  // Result stream.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // traversable[0], reason[3:1], close_neighbours[7:4]
  output logic [hmt_pkg::M_DATA_W-1:0]    m_tdata
);

  import hmt_pkg::*;

  localparam int CELLS = MAX_X * MAX_Y;
  localparam int AW    = $clog2(CELLS);
  localparam int DW    = HEIGHT_BITS + 3;
  localparam int EXW   = $clog2(MAX_X + 1);
  localparam int EYW   = $clog2(MAX_Y + 1);
  localparam int CW0   = (EXW > SIZE_W) ? EXW : SIZE_W;
  localparam int CW    = (EYW > CW0) ? EYW : CW0;

  // Configuration registers.
  logic [SIZE_W-1:0]  grid_x;
  logic [SIZE_W-1:0]  grid_y;
  logic [HDIFF_W-1:0] hdiff_limit;
  logic [SLOPE_W-1:0] slope_limit;

  // Sequencer.
  state_t            state, state_next;
  logic [STEP_W-1:0] step;
  logic [AW-1:0]     clr_cnt;
  logic [7:0]        qx, qy;
  logic              q_inside;
  logic              rd_pend;
  logic [STEP_W-1:0] rd_tag;
  logic              rd_ok;

  // Sizes in use and address generation.
  logic [EXW-1:0] ex;
  logic [EYW-1:0] ey;
  logic           in_inside;
  off_t           ox, oy;
  logic [8:0]     nx, ny;
  logic           nx_ok, ny_ok;

  // Store ports.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata;

  // Handshake decodes.
  logic      in_acc;
  logic      wr_acc;
  logic      qry_acc;
  logic      out_load;
  eval_ctl_t ctl;
  eval_res_t res;

  assign cfg_ready = 1'b1;

  // Configuration writes, taken in every state.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_x      <= SIZE_W'(256);
      grid_y      <= SIZE_W'(256);
      hdiff_limit <= HDIFF_W'(48);
      slope_limit <= SLOPE_W'(341);
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GRID_X: grid_x      <= cfg_data[SIZE_W-1:0];
        CFG_GRID_Y: grid_y      <= cfg_data[SIZE_W-1:0];
        CFG_HDIFF:  hdiff_limit <= cfg_data[HDIFF_W-1:0];
        CFG_SLOPE:  slope_limit <= cfg_data[SLOPE_W-1:0];
      endcase
    end
  end

  // Grid size in use: zero reads as one, large values clamp to the maximum.
  always_comb begin
    priority if (grid_x == '0) begin
      ex = EXW'(1);
    end else if (32'(grid_x) > 32'(MAX_X)) begin
      ex = EXW'(MAX_X);
    end else begin
      ex = EXW'(grid_x);
    end
    priority if (grid_y == '0) begin
      ey = EYW'(1);
    end else if (32'(grid_y) > 32'(MAX_Y)) begin
      ey = EYW'(MAX_Y);
    end else begin
      ey = EYW'(grid_y);
    end
  end

  assign in_inside = (CW'(s_tdata[7:0]) < CW'(ex)) && (CW'(s_tdata[15:8]) < CW'(ey));
  assign in_acc    = s_tvalid && s_tready;
  assign wr_acc    = in_acc && !s_tuser;
  assign qry_acc   = in_acc && s_tuser;
  assign out_load  = (state == ST_DONE) && (!m_tvalid || m_tready);

  // Neighbor coordinates and grid bounds of the current read step.
  always_comb begin
    ox = off_x(step);
    oy = off_y(step);
    unique case (ox)
      OFF_M: begin
        nx    = {1'b0, qx} - 9'd1;
        nx_ok = (qx != 8'd0);
      end
      OFF_P: begin
        nx    = {1'b0, qx} + 9'd1;
        nx_ok = CW'(nx) < CW'(ex);
      end
      default: begin
        nx    = {1'b0, qx};
        nx_ok = 1'b1;
      end
    endcase
    unique case (oy)
      OFF_M: begin
        ny    = {1'b0, qy} - 9'd1;
        ny_ok = (qy != 8'd0);
      end
      OFF_P: begin
        ny    = {1'b0, qy} + 9'd1;
        ny_ok = CW'(ny) < CW'(ey);
      end
      default: begin
        ny    = {1'b0, qy};
        ny_ok = 1'b1;
      end
    endcase
  end

  assign mem_raddr = AW'(nx) * AW'(MAX_Y) + AW'(ny);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == AW'(CELLS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (qry_acc) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step == LAST_STEP) begin
          state_next = ST_GRAD;
        end
      end
      ST_GRAD: state_next = ST_SQX;
      ST_SQX:  state_next = ST_SQY;
      ST_SQY:  state_next = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_tready   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = AW'(s_tdata[7:0]) * AW'(MAX_Y) + AW'(s_tdata[15:8]);
    mem_wdata  = {s_tdata[26], s_tdata[25], s_tdata[24], HEIGHT_BITS'(s_tdata[23:16])};
    mem_re     = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        mem_we   = wr_acc && in_inside;
      end
      ST_RUN: begin
        mem_re = (step <= LAST_READ);
      end
      default: begin
      end
    endcase
    ctl.start      = qry_acc;
    ctl.cap_center = rd_pend && (rd_tag == TAG_CENTER);
    ctl.nb_use     = rd_pend && (rd_tag != TAG_CENTER);
    ctl.nb_sel     = rd_tag;
    ctl.nb_ok      = rd_ok;
    ctl.calc_g     = (state == ST_GRAD);
    ctl.sq_x       = (state == ST_SQX);
    ctl.sq_y       = (state == ST_SQY);
  end

  // State, clear sweep and read step counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      step    <= '0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= mem_re;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (qry_acc) begin
        step <= '0;
      end else if (state == ST_RUN) begin
        step <= step + STEP_W'(1);
      end
    end
  end

  // Query coordinates and the tag of the read in flight.
  always_ff @(posedge clk) begin
    if (qry_acc) begin
      qx       <= s_tdata[7:0];
      qy       <= s_tdata[15:8];
      q_inside <= in_inside;
    end
    rd_tag <= step;
    rd_ok  <= nx_ok && ny_ok;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {res.close_cnt, res.reason, res.reason == RSN_OK};
    end
  end

  hmt_store #(
    .DEPTH (CELLS),
    .AW    (AW),
    .DW    (DW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  hmt_eval #(
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_eval (
    .clk         (clk),
    .ctl         (ctl),
    .q_inside    (q_inside),
    .rdata       (mem_rdata),
    .hdiff_limit (hdiff_limit),
    .slope_limit (slope_limit),
    .res         (res)
  );

endmodule

/* hdl/hmt_checker.sv */
// ---------------------------------------------------------------------------
// hmt_checker
// Port-level checks of the traversability block, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hmt_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [hmt_pkg::M_DATA_W-1:0] m_tdata
);

  import hmt_pkg::*;

  // Fields of the result beat.
  logic [2:0] rsn;
  logic [3:0] ncl;
  logic       no_col;
  logic       past_cont;

  assign rsn       = m_tdata[3:1];
  assign ncl       = m_tdata[7:4];
  assign no_col    = (rsn == RSN_BLOCKED) || (rsn == RSN_NO_SURFACE);
  assign past_cont = (rsn == RSN_OK) || (rsn == RSN_STEEP) || (rsn == RSN_INFLATED);

  // A stalled result beat holds.
  `HMT_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

  // The traversable flag agrees with the reason code.
  `HMT_ASSERT(a_trav_reason, m_tvalid |-> (m_tdata[0] == (rsn == RSN_OK)))

  // Blocked or missing columns report no close neighbors.
  `HMT_ASSERT(a_close_zero, m_tvalid && no_col |-> ncl == 4'd0)

  // Reasons past the continuity check need enough close neighbors.
  `HMT_ASSERT(a_close_enough, m_tvalid && past_cont |-> ncl >= 4'(NEED_CLOSE) && ncl <= 4'd8)

  // Reset starts the clear sweep with nothing offered on either side.
  `HMT_ASSERT_RST(a_reset_quiet, rst |=> !s_tready && !m_tvalid)

endmodule

bind heightmap_traversability_check_top hmt_checker u_hmt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* verif/heightmap_traversability_check_top_test.sv */
// ---------------------------------------------------------------------------
// Heightmap traversability check: self-checking stream testbench
// Drives write and query beats into the block, keeps its own copy of the
// column store and registers, classifies every accepted query the same way
// and compares each result beat field by field, with random gaps on both
// stream sides and register changes only while the block is idle.
// ---------------------------------------------------------------------------
module heightmap_traversability_check_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hmt_pkg::*;

  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 9;
  localparam int GRID_X         = MAX_X_DEF;
  localparam int GRID_Y         = MAX_Y_DEF;
  localparam int SETTLE_CYCLES  = 24;
  // The clearing sweep after reset accepts nothing until every entry is cleared.
  localparam int WATCHDOG_LIMIT = 4 * GRID_X * GRID_Y + 20000;
  localparam int MAX_REPORTS    = 100;
  localparam int TERRAIN_PHASES = 8;
  localparam int WIN            = 5;
  localparam int PHASE_MIX      = 55;

  // Command carried in tuser.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // One input beat before packing.
  typedef struct packed {
    logic       cmd;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] height;
    logic       present;
    logic       blocked;
    logic       inflated;
  } column_op_t;

  // Classification expected for one query.
  typedef struct {
    logic [7:0] qx;
    logic [7:0] qy;
    logic       traversable;
    reason_t    reason;
    logic [3:0] close_cnt;
  } verdict_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata   = '0;
  logic                  s_tuser   = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;

  // Shadow registers, at their reset values.
  logic [8:0]  size_x_reg       = 9'd256;
  logic [8:0]  size_y_reg       = 9'd256;
  logic [11:0] height_limit_reg = 12'd48;
  logic [27:0] slope_limit_reg  = 28'd341;

  // Shadow column store; all zero means no surface, not blocked, not inflated.
  bit [7:0] col_height   [GRID_X][GRID_Y];
  bit       col_present  [GRID_X][GRID_Y];
  bit       col_blocked  [GRID_X][GRID_Y];
  bit       col_inflated [GRID_X][GRID_Y];

  verdict_t pending_verdicts[$];
  int       mismatch_count = 0;
  bit       quiet_mode     = 1'b0;

  heightmap_traversability_check_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // Idle length: mostly none, often short, sometimes long.
  function automatic int pick_gap();
    int r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Size in use along one axis: zero counts as one, the grid caps the rest.
  function automatic int span_of(logic [8:0] r, int cap);
    if (r == 0) return 1;
    if (int'(r) > cap) return cap;
    return int'(r);
  endfunction

  // Height of a column that lies in the grid and has a surface.
  function automatic bit surface_at(int x, int y, output int h);
    h = 0;
    if (x < 0 || y < 0) return 1'b0;
    if (x >= span_of(size_x_reg, GRID_X) || y >= span_of(size_y_reg, GRID_Y)) return 1'b0;
    if (!col_present[x][y]) return 1'b0;
    h = col_height[x][y];
    return 1'b1;
  endfunction

  // Central difference, or a doubled one-sided difference.
  function automatic int axis_slope(bit has_p, int hp, bit has_m, int hm, int h);
    if (has_p && has_m) return hp - hm;
    if (has_p) return 2 * (hp - h);
    if (has_m) return 2 * (h - hm);
    return 0;
  endfunction

  // Classifies one column against the shadow store and registers.
  function automatic verdict_t judge_column(logic [7:0] x, logic [7:0] y);
    verdict_t v;
    int       cx, cy, h, nh, d, close, gx, gy;
    int       hxp, hxm, hyp, hym;
    bit       sxp, sxm, syp, sym;
    longint   mag;
    cx = int'(x);
    cy = int'(y);
    v.qx = x;
    v.qy = y;
    v.reason = RSN_OK;
    close = 0;
    if (cx >= span_of(size_x_reg, GRID_X) || cy >= span_of(size_y_reg, GRID_Y)) begin
      v.reason = RSN_NO_SURFACE;
    end else if (col_blocked[cx][cy]) begin
      v.reason = RSN_BLOCKED;
    end else if (!surface_at(cx, cy, h)) begin
      v.reason = RSN_NO_SURFACE;
    end else begin
      // Count the neighbors whose height step stays under the threshold.
      for (int dx = -1; dx <= 1; dx++) begin
        for (int dy = -1; dy <= 1; dy++) begin
          if ((dx != 0 || dy != 0) && surface_at(cx + dx, cy + dy, nh)) begin
            d = (nh > h) ? nh - h : h - nh;
            if (16 * d < int'(height_limit_reg)) close++;
          end
        end
      end
      if (close < NEED_CLOSE) begin
        v.reason = RSN_DISCONT;
      end else begin
        sxp = surface_at(cx + 1, cy, hxp);
        sxm = surface_at(cx - 1, cy, hxm);
        syp = surface_at(cx, cy + 1, hyp);
        sym = surface_at(cx, cy - 1, hym);
        gx  = axis_slope(sxp, hxp, sxm, hxm, h);
        gy  = axis_slope(syp, hyp, sym, hym, h);
        mag = 256 * (longint'(gx) * gx + longint'(gy) * gy);
        if (mag > longint'(slope_limit_reg)) v.reason = RSN_STEEP;
        else if (col_inflated[cx][cy]) v.reason = RSN_INFLATED;
      end
    end
    v.close_cnt   = close[3:0];
    v.traversable = (v.reason == RSN_OK);
    return v;
  endfunction

  // Updates the shadow store for an accepted beat, or queues its verdict.
  function automatic void apply_column_op(column_op_t op);
    int       cx, cy;
    verdict_t v;
    cx = int'(op.x);
    cy = int'(op.y);
    if (op.cmd == CMD_QUERY) begin
      v = judge_column(op.x, op.y);
      pending_verdicts.insert(pending_verdicts.size(), v);
    end else if (cx < span_of(size_x_reg, GRID_X) && cy < span_of(size_y_reg, GRID_Y)) begin
      col_height[cx][cy]   = op.height;
      col_present[cx][cy]  = op.present;
      col_blocked[cx][cy]  = op.blocked;
      col_inflated[cx][cy] = op.inflated;
    end
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("[%0t] ERROR: %s", $time, what);
  endtask

  // Sends one beat; valid stays high when the next beat follows at once.
  task automatic send_column_op(column_op_t op);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op.cmd;
    s_tdata  <= {5'b0, op.inflated, op.blocked, op.present, op.height, op.y, op.x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    apply_column_op(op);
  endtask

  task automatic put_column(int x, int y, int h, bit present, bit blocked, bit inflated);
    column_op_t op;
    op.cmd      = CMD_WRITE;
    op.x        = x[7:0];
    op.y        = y[7:0];
    op.height   = h[7:0];
    op.present  = present;
    op.blocked  = blocked;
    op.inflated = inflated;
    send_column_op(op);
  endtask

  // Query beat; the write-only fields carry random values.
  task automatic ask_column(int x, int y);
    column_op_t op;
    op.cmd      = CMD_QUERY;
    op.x        = x[7:0];
    op.y        = y[7:0];
    op.height   = 8'($urandom);
    op.present  = 1'($urandom);
    op.blocked  = 1'($urandom);
    op.inflated = 1'($urandom);
    send_column_op(op);
  endtask

  // Waits until every query has answered and any trailing write is done.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(cfg_idx_t idx, logic [27:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_GRID_X: size_x_reg       = value[8:0];
      CFG_GRID_Y: size_y_reg       = value[8:0];
      CFG_HDIFF:  height_limit_reg = value[11:0];
      CFG_SLOPE:  slope_limit_reg  = value;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(int gx, int gy, int hd, int sl);
    wait_idle();
    write_register(CFG_GRID_X, 28'(gx));
    write_register(CFG_GRID_Y, 28'(gy));
    write_register(CFG_HDIFF, 28'(hd));
    write_register(CFG_SLOPE, 28'(sl));
  endtask

  // Reset values, empty store, extreme indexes and heights, blocked over no surface.
  task automatic test_store_edges();
    ask_column(0, 0);
    put_column(255, 255, 255, 1'b1, 1'b0, 1'b0);
    ask_column(255, 255);
    put_column(255, 255, 0, 1'b0, 1'b1, 1'b1);
    ask_column(255, 255);
  endtask

  // A flat patch, then a steep step and an inflated center.
  task automatic test_reason_codes();
    for (int x = 20; x <= 22; x++) begin
      for (int y = 30; y <= 32; y++) begin
        put_column(x, y, 128, 1'b1, 1'b0, 1'b0);
      end
    end
    ask_column(21, 31);
    put_column(22, 31, 140, 1'b1, 1'b0, 1'b0);
    ask_column(21, 31);
    put_column(22, 31, 128, 1'b1, 1'b0, 1'b0);
    put_column(21, 31, 128, 1'b1, 1'b0, 1'b1);
    ask_column(21, 31);
  endtask

  // Shrunk grid hides neighbors, queries and writes outside it.
  task automatic test_grid_limits();
    apply_settings(22, 32, 48, 341);
    ask_column(21, 31);
    ask_column(22, 31);
    put_column(25, 31, 7, 1'b1, 1'b1, 1'b0);
    apply_settings(256, 256, 48, 341);
    ask_column(25, 31);
  endtask

  // One phase: a register setting, a filled window, then mixed traffic.
  task automatic run_terrain_phase(int p);
    int gx, gy, hd, sl, wx, wy;
    int base, spread, stride, offset, slot, pick;
    column_op_t op;
    hd = $urandom_range(16, 160);
    sl = $urandom_range(0, 4000);
    wx = $urandom_range(1, 250);
    wy = $urandom_range(1, 250);
    gx = 256;
    gy = 256;
    case (p)
      1: begin
        gx = 3;
        gy = 511;
        hd = 4095;
        sl = 28'hFFFFFFF;
        wx = 0;
      end
      2: begin
        gx = 0;
        gy = 9;
        hd = 0;
        sl = 0;
        wx = 0;
        wy = 0;
      end
      3: begin
        gx = $urandom_range(1, 8);
        gy = $urandom_range(1, 8);
        sl = 0;
        wx = 0;
        wy = 0;
      end
      4: begin
        gx = 511;
        sl = $urandom_range(0, 1 << 20);
        wx = 251;
        wy = 251;
      end
      6: begin
        gx = 255;
        gy = $urandom_range(200, 256);
        wx = 250;
      end
      7: begin
        gx = $urandom_range(128, 511);
        gy = $urandom_range(128, 511);
        hd = $urandom_range(16, 400);
        sl = $urandom_range(0, 20000);
        wx = $urandom_range(0, 120);
        wy = $urandom_range(0, 120);
      end
      default: ;
    endcase
    apply_settings(gx, gy, hd, sl);
    quiet_mode = (p == 5);

    // Mostly gentle terrain, sometimes rough.
    spread = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 3);
    base   = $urandom_range(0, 255 - spread);

    // Fill the window in a scrambled order; strides 1..4 visit every column once.
    stride = $urandom_range(1, 4);
    offset = $urandom_range(0, WIN * WIN - 1);
    for (int k = 0; k < WIN * WIN; k++) begin
      slot = (k * stride + offset) % (WIN * WIN);
      put_column(wx + slot % WIN, wy + slot / WIN, base + $urandom_range(0, spread),
                 $urandom_range(0, 99) < 92, $urandom_range(0, 99) < 5,
                 $urandom_range(0, 99) < 15);
    end

    // Rewrites and queries inside the window, with some fully random beats.
    for (int n = 0; n < PHASE_MIX; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        put_column(wx + $urandom_range(0, WIN - 1), wy + $urandom_range(0, WIN - 1),
                   base + $urandom_range(0, spread), $urandom_range(0, 99) < 85,
                   $urandom_range(0, 99) < 8, $urandom_range(0, 99) < 20);
      end else if (pick < 80) begin
        ask_column(wx + $urandom_range(0, WIN - 1), wy + $urandom_range(0, WIN - 1));
      end else begin
        op = 28'($urandom);
        send_column_op(op);
      end
    end
    quiet_mode = 1'b0;
  endtask

  task automatic test_random_terrain();
    for (int p = 0; p < TERRAIN_PHASES; p++) begin
      run_terrain_phase(p);
    end
  endtask

  // Result side back-pressure.
  always begin : result_ready_pacer
    int hold;
    @(posedge clk);
    hold = pick_gap();
    if (hold > 0) begin
      m_tready <= 1'b0;
      repeat (hold) @(posedge clk);
    end
    m_tready <= 1'b1;
  end

  // Compares each result beat with the oldest queued verdict.
  always @(posedge clk) begin : result_checker
    verdict_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("result beat %h with no query pending", m_tdata));
      end else begin
        want = pending_verdicts.pop_front();
        if (m_tdata[0] !== want.traversable)
          report_mismatch($sformatf("col (%0d,%0d) traversable %b, want %b",
                                    want.qx, want.qy, m_tdata[0], want.traversable));
        if (m_tdata[3:1] !== want.reason)
          report_mismatch($sformatf("col (%0d,%0d) reason %0d, want %0d",
                                    want.qx, want.qy, m_tdata[3:1], want.reason));
        if (m_tdata[7:4] !== want.close_cnt)
          report_mismatch($sformatf("col (%0d,%0d) close neighbors %0d, want %0d",
                                    want.qx, want.qy, m_tdata[7:4], want.close_cnt));
      end
    end
  end

  // Ends the run when no beat moves on any channel for too long.
  initial begin : stall_watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("heightmap_traversability_check_top: mismatch");
    $finish;
  end

  initial begin : run_sequence
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_store_edges();
    test_reason_codes();
    test_grid_limits();
    test_random_terrain();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("heightmap_traversability_check_top: match");
    end else begin
      $display("heightmap_traversability_check_top: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/hmt_pkg.sv
hdl/hmt_store.sv
hdl/hmt_eval.sv
hdl/heightmap_traversability_check_top.sv
hdl/hmt_checker.sv
verif/heightmap_traversability_check_top_test.sv
